### hdl/nba_pkg.sv
// Shared types, constants and helper functions for the nearest box assignment block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nba_pkg;

    localparam int MAX_BOXES_DEF = 64;

    // distance pipeline: abs diff, square, sum
    localparam int PIPE_LAT = 3;
    localparam int DIFF_W   = 17;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int BEST_W   = 32;

    localparam logic [15:0] RADIUS_RST = 16'd200;

    // function codes on i_func
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // box reference point, 18-bit signed per axis
    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } t_center;

    // query centroid
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    // position plus floor of half the extent
    function automatic logic signed [17:0] axis_center(
        input logic signed [15:0] pos,
        input logic        [15:0] size
    );
        return {{2{pos[15]}}, pos} + {3'b000, size[15:1]};
    endfunction

    // |c - q|, at most 98302, fits 17 bits
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [17:0] c,
        input logic signed [15:0] q
    );
        logic signed [18:0] d;
        d = {c[17], c} - {{3{q[15]}}, q};
        return d[18] ? DIFF_W'(-d) : d[DIFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/nba_cell.sv
// One table slot of the box ring: holds a box reference point.
// Loaded by an append write, or takes its neighbor's point while the ring rotates. Uses nba_pkg.
`default_nettype none

module nba_cell
    import nba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_shift,
    input  wire t_center i_next,
    input  wire logic    i_we,
    input  wire t_center i_wdata,
    output t_center      o_data
);

    t_center r_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_data <= i_wdata;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### hdl/nba_dist.sv
// Squared distance pipeline and running best for the box scan.
// abs diff -> square -> sum -> compare against best. Uses nba_pkg.
`default_nettype none

module nba_dist
    import nba_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [BEST_W-1:0] i_radius_sq,
    input  wire logic              i_valid,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_center           i_center,
    input  wire t_point            i_query,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_idx
);

    logic              r_a_valid, r_b_valid, r_c_valid;
    logic [IDX_W-1:0]  r_a_idx, r_b_idx, r_c_idx;
    logic [DIFF_W-1:0] r_a_dx, r_a_dy, r_a_dz;
    logic [SQ_W-1:0]   r_b_sx, r_b_sy, r_b_sz;
    logic [SUM_W-1:0]  r_c_sum;
    logic [BEST_W-1:0] r_best;
    logic              r_found;
    logic [IDX_W-1:0]  r_idx;
    logic              w_better;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            if (i_start) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        r_a_dx  <= abs_diff(i_center.x, i_query.x);
        r_a_dy  <= abs_diff(i_center.y, i_query.y);
        r_a_dz  <= abs_diff(i_center.z, i_query.z);

        r_b_idx <= r_a_idx;
        r_b_sx  <= r_a_dx * r_a_dx;
        r_b_sy  <= r_a_dy * r_a_dy;
        r_b_sz  <= r_a_dz * r_a_dz;

        r_c_idx <= r_b_idx;
        r_c_sum <= SUM_W'(r_b_sx) + SUM_W'(r_b_sy) + SUM_W'(r_b_sz);

        if (i_start) begin
            r_best <= i_radius_sq;
            r_idx  <= '0;
        end else if (w_better) begin
            r_best <= r_c_sum[BEST_W-1:0];
            r_idx  <= r_c_idx;
        end
    end

    // strict less: ties keep the lower index
    assign w_better = r_c_valid && (r_c_sum < SUM_W'(r_best));

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

`default_nettype wire

### hdl/nearest_box_assignment.sv
// Nearest box assignment, top level: sequencer, ring of box cells, result registers.
// Depends on nba_pkg, nba_cell and nba_dist.
//
// Keeps up to MAX_BOXES box reference points (position plus half extent, per
// axis) and answers three kinds of word on the input channel: clear empties
// the table, append stores one box at the next free slot (or drops it with
// status 1 when the table is full), query returns the lowest-indexed box whose
// squared distance to the centroid is strictly the least and strictly below
// match_radius squared. Every word gives exactly one result word.
// The table is a ring of MAX_BOXES cells. A query rotates the ring once, one
// entry a cycle past a single three-stage distance unit, so the ring ends back
// where it started. A query holds off the next word until the ring rotation
// and the distance pipeline have run and its result has left the pending
// register. One finished result can wait in a pending register while the
// output register is stalled, so a new word is still taken while the
// previous result sits on the output.
// match_radius is written through i_cfg_we / i_cfg_data; the user must write it
// only while idle, the block itself does not enforce this. It resets to 200.
// box_index is the low 6 bits of the table index and box_total the low 7 bits of the count.
`default_nettype none

module nearest_box_assignment
    import nba_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    // input words
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic signed [15:0] i_pos_z,
    input  wire logic [15:0]        i_size_x,
    input  wire logic [15:0]        i_size_y,
    input  wire logic [15:0]        i_size_z,
    input  wire logic signed [15:0] i_cent_x,
    input  wire logic signed [15:0] i_cent_y,
    input  wire logic signed [15:0] i_cent_z,
    // result words
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_status,
    output logic                    o_found,
    output logic [5:0]              o_box_index,
    output logic [6:0]              o_box_total
);

    localparam int IDX_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W    = $clog2(MAX_BOXES + 1);
    localparam int SCAN_END = MAX_BOXES + PIPE_LAT;
    localparam int SEQ_W    = $clog2(SCAN_END + 1);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SCAN = 1'b1;

    logic [0:0]       r_state, n_state;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_radius;
    t_point           r_query;

    // pending result, waits for the output register
    logic             r_pend_valid, n_pend_valid;
    logic             r_pend_status, n_pend_status;
    logic             r_pend_found, n_pend_found;
    logic [5:0]       r_pend_idx, n_pend_idx;
    logic [6:0]       r_pend_total, n_pend_total;

    // output register
    logic             r_out_valid;
    logic             r_out_status, r_out_found;
    logic [5:0]       r_out_idx;
    logic [6:0]       r_out_total;

    logic              w_in_acc, w_full, w_app_write, w_shift, w_issue;
    logic              w_pend_move, w_start;
    logic [BEST_W-1:0] w_radius_sq;
    logic              w_found;
    logic [IDX_W-1:0]  w_best_idx;
    t_center           w_new_center;
    t_center           w_cell [MAX_BOXES];

    assign o_in_stall = !((r_state == ST_IDLE) && !r_pend_valid);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count >= CNT_W'(MAX_BOXES));
    assign w_start    = w_in_acc && (i_func == FUNC_QUERY);

    // ring rotates exactly MAX_BOXES times per query, back to home position
    assign w_shift = (r_state == ST_SCAN) && (r_seq < SEQ_W'(MAX_BOXES));
    assign w_issue = w_shift && (r_seq < SEQ_W'(r_count));

    assign w_radius_sq = {16'b0, r_radius} * {16'b0, r_radius};

    assign w_new_center.x = axis_center(i_pos_x, i_size_x);
    assign w_new_center.y = axis_center(i_pos_y, i_size_y);
    assign w_new_center.z = axis_center(i_pos_z, i_size_z);

    // ---- table ring: cell 0 feeds the distance unit ----
    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        localparam int NXT = (k + 1) % MAX_BOXES;
        nba_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_next  (w_cell[NXT]),
            .i_we    (w_app_write && (r_count == CNT_W'(k))),
            .i_wdata (w_new_center),
            .o_data  (w_cell[k])
        );
    end

    nba_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_radius_sq (w_radius_sq),
        .i_valid     (w_issue),
        .i_idx       (r_seq[IDX_W-1:0]),
        .i_center    (w_cell[0]),
        .i_query     (r_query),
        .o_found     (w_found),
        .o_idx       (w_best_idx)
    );

    // ---- sequencer ----
    assign w_pend_move = r_pend_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state       = r_state;
        n_seq         = r_seq;
        n_count       = r_count;
        n_pend_valid  = r_pend_valid;
        n_pend_status = r_pend_status;
        n_pend_found  = r_pend_found;
        n_pend_idx    = r_pend_idx;
        n_pend_total  = r_pend_total;
        w_app_write   = 1'b0;

        if (w_pend_move) begin
            n_pend_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_pend_valid  = 1'b1;
                    n_pend_status = 1'b0;
                    n_pend_found  = 1'b0;
                    n_pend_idx    = '0;
                    case (i_func)
                        FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        FUNC_APPEND: begin
                            if (w_full) begin
                                n_pend_status = 1'b1;
                            end else begin
                                w_app_write = 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            // result comes at the end of the scan
                            n_pend_valid = 1'b0;
                            n_seq        = '0;
                            n_state      = ST_SCAN;
                        end
                        default: begin
                            // unused code: table untouched
                        end
                    endcase
                    n_pend_total = 7'(n_count);
                end
            end
            ST_SCAN: begin
                n_seq = r_seq + 1'b1;
                if (r_seq == SEQ_W'(SCAN_END)) begin
                    n_state       = ST_IDLE;
                    n_pend_valid  = 1'b1;
                    n_pend_status = 1'b0;
                    n_pend_found  = w_found;
                    n_pend_idx    = 6'(w_best_idx);
                    n_pend_total  = 7'(r_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seq        <= '0;
            r_count      <= '0;
            r_radius     <= RADIUS_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seq        <= n_seq;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_found  <= n_pend_found;
        r_pend_idx    <= n_pend_idx;
        r_pend_total  <= n_pend_total;
        if (w_start) begin
            r_query.x <= i_cent_x;
            r_query.y <= i_cent_y;
            r_query.z <= i_cent_z;
        end
        if (w_pend_move) begin
            r_out_status <= r_pend_status;
            r_out_found  <= r_pend_found;
            r_out_idx    <= r_pend_idx;
            r_out_total  <= r_pend_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_box_index = r_out_idx;
    assign o_box_total = r_out_total;

    // ---- checks ----
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count above table size");

    a_no_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_pend_valid)
        else $error("pending result while a scan runs");

    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_SCAN) && (r_seq == '0))
        else $error("accepted query did not start a scan");

    a_match_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_seq == SEQ_W'(SCAN_END)) && w_found)
            |-> (CNT_W'(w_best_idx) < r_count))
        else $error("match index outside filled table");

endmodule

`default_nettype wire
